// File: rtl/cco_pkg.sv
// ----------------------------------------------------------------------------
// cco_pkg: shared types and constants of the Coppock curve oscillator.
// Holds the store geometry, the sequencer state type and the divider width.
// ----------------------------------------------------------------------------
package cco_pkg;

  localparam int MAX_LONG_LAG   = 32;
  localparam int MAX_WMA_LENGTH = 16;
  localparam int PRICE_WIDTH    = 32;
  localparam int VAL_WIDTH      = 40;
  localparam int PA_WIDTH       = $clog2(MAX_LONG_LAG);
  localparam int TA_WIDTH       = $clog2(MAX_WMA_LENGTH);
  localparam int SUM_WIDTH      = VAL_WIDTH + 2 * TA_WIDTH + 2;
  localparam int DIVW           = 64;
  localparam logic [31:0] RATE_SCALE = 32'd6553600;
  localparam logic [VAL_WIDTH-1:0] VAL_MAX = '1;

  typedef enum logic [1:0] {
    REG_LONG_LAG   = 2'd0,
    REG_SHORT_LAG  = 2'd1,
    REG_WMA_LENGTH = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_LONG,
    ST_RD_SHORT,
    ST_DIV_LONG,
    ST_DIV_SHORT,
    ST_STORE,
    ST_MAC_RD,
    ST_MAC,
    ST_AVG,
    ST_OUT
  } state_t;

endpackage

// File: rtl/cco_stream_if.sv
// ----------------------------------------------------------------------------
// cco_stream_if: valid/ready channel with a generic payload.
// Used for both the price input and the oscillator output.
// ----------------------------------------------------------------------------
interface cco_stream_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/cco_divider.sv
// ----------------------------------------------------------------------------
// cco_divider: restoring divider, one quotient bit per cycle.
// Divides a 64-bit dividend by a 64-bit divisor; divisor is nonzero.
// ----------------------------------------------------------------------------
module cco_divider
  import cco_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DIVW-1:0] dividend,
  input  logic [DIVW-1:0] divisor,
  output logic            busy,
  output logic            done,
  output logic [DIVW-1:0] quotient
);

  localparam int CW = $clog2(DIVW);

  logic [DIVW-1:0] rem;
  logic [DIVW-1:0] quo;
  logic [DIVW-1:0] den;
  logic [CW-1:0]   count;
  logic [DIVW:0]   trial;

  // One shift-and-subtract step.
  always_comb begin
    trial = {rem, quo[DIVW-1]} - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CW'(DIVW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      den <= divisor;
    end else if (busy) begin
      if (!trial[DIVW]) begin
        rem <= trial[DIVW-1:0];
        quo <= {quo[DIVW-2:0], 1'b1};
      end else begin
        rem <= {rem[DIVW-2:0], quo[DIVW-1]};
        quo <= {quo[DIVW-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

// File: rtl/coppock_curve_oscillator.sv
// ----------------------------------------------------------------------------
// coppock_curve_oscillator: ratio-form Coppock curve in fixed point.
// ----------------------------------------------------------------------------
// Usage: prices enter on price_in (close_price, start_series) and results
// leave on osc_out (oscillator_value, price_zero, config_error). Registers
// long_lag, short_lag and wma_length are written through cfg_we, cfg_index
// and cfg_data while the block is idle.
// Each beat is worked by a small sequencer around one shared 64-bit
// restoring divider. A sample past warm-up with a valid configuration runs
// two divisions, and once enough terms are stored, a weighted sum of n
// terms (n = wma_length clamped to 1..16) and a final division before its
// result beat is offered. A zero divisor price skips its division. A
// config-error sample goes straight to its result beat. price_in.ready is
// low while a sample is in progress.
// A result waits in an output register; the next beat is taken only after
// it has left, so a stalled receiver holds the whole block.
// Reset clears the pointers, counters and flags and loads the register
// defaults 14, 11 and 10. The history stores are not cleared; counters keep
// unwritten entries from being read. start_series restarts the series.
// ----------------------------------------------------------------------------
module coppock_curve_oscillator
  import cco_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data,
  cco_stream_if.sink   price_in,
  cco_stream_if.source osc_out
);

  // Configuration registers.
  logic [5:0] long_lag;
  logic [5:0] short_lag;
  logic [4:0] wma_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_lag   <= 6'd14;
      short_lag  <= 6'd11;
      wma_length <= 5'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LONG_LAG:   long_lag   <= cfg_data;
        REG_SHORT_LAG:  short_lag  <= cfg_data;
        REG_WMA_LENGTH: wma_length <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Clamped register values.
  logic [5:0] ll, sl;
  logic [4:0] n;
  always_comb begin
    ll = (long_lag == '0) ? 6'd1 : (long_lag > 6'd32) ? 6'd32 : long_lag;
    sl = (short_lag == '0) ? 6'd1 : (short_lag > 6'd32) ? 6'd32 : short_lag;
    n  = (wma_length == '0) ? 5'd1 : (wma_length > 5'd16) ? 5'd16 : wma_length;
  end

  // Input beat and sequencer.
  state_t state, state_next;
  logic   in_fire, out_fire;
  logic [PRICE_WIDTH-1:0] close;

  logic [PRICE_WIDTH-1:0] price_mem [MAX_LONG_LAG];
  logic [VAL_WIDTH-1:0]   term_mem  [MAX_WMA_LENGTH];
  logic [PRICE_WIDTH-1:0] price_rd;
  logic [VAL_WIDTH-1:0]   term_rd;
  logic [PA_WIDTH-1:0]    price_wp, price_ra;
  logic [TA_WIDTH-1:0]    term_wp, term_ra;
  logic [5:0]             samples_seen;
  logic [4:0]             terms_seen;
  logic [MAX_WMA_LENGTH-1:0] zero_win;

  logic [PRICE_WIDTH-1:0] pl, ps;
  logic [VAL_WIDTH-1:0]   qa;
  logic [VAL_WIDTH:0]     tsum;
  logic [4:0]             k;
  logic [SUM_WIDTH-1:0]   acc;
  logic [VAL_WIDTH-1:0]   res_val;
  logic                   res_zero, res_cerr;
  logic                   has_term;

  logic            div_start, div_busy, div_done;
  logic [DIVW-1:0] div_a, div_b, div_q;
  logic [DIVW-1:0] scaled;

  assign in_fire  = price_in.valid && price_in.ready;
  assign out_fire = osc_out.valid && osc_out.ready;
  assign price_in.ready = (state == ST_IDLE);
  assign osc_out.valid  = (state == ST_OUT);
  assign osc_out.data   = {res_val, res_zero, res_cerr};

  assign scaled = 64'(close) * 64'(RATE_SCALE);
  assign has_term = (samples_seen >= ll);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (sl > ll) state_next = ST_OUT;
          else if (price_in.data[0] || !(samples_seen >= ll)) state_next = ST_STORE;
          else state_next = ST_RD_LONG;
        end
      end
      ST_RD_LONG:   state_next = ST_RD_SHORT;
      ST_RD_SHORT:  state_next = ST_DIV_LONG;
      ST_DIV_LONG:  if (pl == '0 || div_done) state_next = ST_DIV_SHORT;
      ST_DIV_SHORT: if (ps == '0 || div_done) state_next = ST_STORE;
      ST_STORE: begin
        if (((has_term ? terms_seen + 5'd1 : terms_seen) >= n) ||
            (has_term && terms_seen == 5'(MAX_WMA_LENGTH)))
          state_next = ST_MAC_RD;
        else
          state_next = ST_IDLE;
      end
      ST_MAC_RD:    state_next = ST_MAC;
      ST_MAC:       state_next = (k == 5'd1) ? ST_AVG : ST_MAC_RD;
      ST_AVG:       if (div_done) state_next = ST_OUT;
      ST_OUT:       if (out_fire) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Divider control outputs. The long-lag price divides first, then the
  // short-lag price; a zero price skips its division.
  always_comb begin
    div_start = 1'b0;
    div_a = scaled;
    div_b = 64'(pl);
    unique case (state)
      ST_RD_SHORT: begin
        div_start = (pl != '0);
        div_b = 64'(pl);
      end
      ST_DIV_LONG: begin
        div_start = (pl == '0 || div_done) && (ps != '0);
        div_b = 64'(ps);
      end
      ST_MAC: begin
        div_start = (k == 5'd1);
        div_a = 64'(acc + SUM_WIDTH'(term_rd) * SUM_WIDTH'(k));
        div_b = 64'((10'(n) * 10'(n + 5'd1)) >> 1);
      end
      default: ;
    endcase
  end

  cco_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Saturated quotient of the divider.
  logic [VAL_WIDTH-1:0] qsat;
  assign qsat = (div_q[DIVW-1:VAL_WIDTH] != '0) ? VAL_MAX : div_q[VAL_WIDTH-1:0];

  // Read addresses: the newest term gets the highest weight k = n.
  always_comb begin
    price_ra = price_wp - PA_WIDTH'(ll);
    if (state == ST_RD_LONG) price_ra = price_wp - PA_WIDTH'(sl);
    term_ra = term_wp + TA_WIDTH'(k) - TA_WIDTH'(n) - TA_WIDTH'(1);
  end

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    price_rd <= price_mem[price_ra];
    term_rd  <= term_mem[term_ra];
    if (state == ST_STORE)
      price_mem[price_wp] <= close;
    if (state == ST_DIV_SHORT && state_next == ST_STORE)
      term_mem[term_wp] <= tsum[VAL_WIDTH] ? VAL_MAX : tsum[VAL_WIDTH-1:0];
  end

  // Control and datapath registers.
  logic do_term;
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      price_wp     <= '0;
      term_wp      <= '0;
      samples_seen <= '0;
      terms_seen   <= '0;
      zero_win     <= '0;
      do_term      <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        do_term <= 1'b0;
        if (price_in.data[0]) begin
          price_wp     <= '0;
          term_wp      <= '0;
          samples_seen <= '0;
          terms_seen   <= '0;
          zero_win     <= '0;
        end
      end
      if (state == ST_DIV_SHORT && state_next == ST_STORE) begin
        do_term <= 1'b1;
        zero_win[term_wp] <= (pl == '0) || (ps == '0);
      end
      if (state == ST_STORE) begin
        price_wp <= price_wp + 1'b1;
        if (samples_seen < 6'(MAX_LONG_LAG)) samples_seen <= samples_seen + 1'b1;
        if (do_term) begin
          term_wp <= term_wp + 1'b1;
          if (terms_seen < 5'(MAX_WMA_LENGTH)) terms_seen <= terms_seen + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      close    <= price_in.data[PRICE_WIDTH:1];
      res_val  <= '0;
      res_zero <= 1'b0;
      res_cerr <= (sl > ll);
    end
    if (state == ST_RD_LONG) pl <= price_rd;
    if (state == ST_RD_SHORT) ps <= price_rd;
    if (state == ST_DIV_LONG) begin
      if (pl == '0) qa <= VAL_MAX;
      else if (div_done) qa <= qsat;
    end
    if (state == ST_STORE) begin
      k   <= n;
      acc <= '0;
      res_zero <= 1'b0;
    end
    if (state == ST_MAC_RD) res_zero <= res_zero | zero_win[term_ra];
    if (state == ST_MAC) begin
      acc <= acc + SUM_WIDTH'(term_rd) * SUM_WIDTH'(k);
      k   <= k - 1'b1;
    end
    if (state == ST_AVG && div_done) res_val <= div_q[VAL_WIDTH-1:0];
  end

  // Sum of the two rate quotients, saturated when written to the term store.
  always_comb begin
    tsum = {1'b0, qa} + {1'b0, (ps == '0) ? VAL_MAX : qsat};
  end

`ifndef SYNTHESIS
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> !price_in.ready) else $error("input taken while dividing");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    osc_out.valid && !osc_out.ready |=> osc_out.valid)
    else $error("result dropped under stall");
  a_cerr_zero: assert property (@(posedge clk) disable iff (rst)
    osc_out.valid && res_cerr |-> res_val == '0)
    else $error("config error with nonzero value");
`endif

endmodule
